FILE: rtl/core/npf_pkg.sv
// ============================================================================
// npf_pkg
// Shared types and constants of the normalized pixel difference feature block.
// ============================================================================
package npf_pkg;

    localparam int PIX_W  = 8;
    localparam int IDX_W  = 6;
    localparam int FIDX_W = 11;
    localparam int NUM_W  = 7;
    localparam int SUM_W  = 9;
    localparam int QUO_W  = 8;

    // Restoring divider: quotient bits resolved per stage, and stage count.
    localparam int DIV_STEPS  = 2;
    localparam int DIV_STAGES = QUO_W / DIV_STEPS;

    localparam logic [PIX_W-1:0] FEAT_BOTH_ZERO = 8'd128;
    localparam logic [PIX_W-1:0] FEAT_SAT       = 8'd255;

    localparam logic [NUM_W-1:0] NUM_RESET = 7'd64;
    localparam logic [NUM_W-1:0] NUM_MIN   = 7'd2;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             start_patch;
    } t_in;

    typedef struct packed {
        logic [PIX_W-1:0]  feature;
        logic [FIDX_W-1:0] feature_index;
        logic [IDX_W-1:0]  first_index;
        logic [IDX_W-1:0]  second_index;
        logic              last;
        logic              patch_end;
    } t_out;

    typedef struct packed {
        logic [FIDX_W-1:0] feature_index;
        logic [IDX_W-1:0]  first_index;
        logic [IDX_W-1:0]  second_index;
        logic              last;
        logic              patch_end;
    } t_meta;

    typedef struct packed {
        logic [PIX_W-1:0] b;
        t_meta            meta;
    } t_iss;

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [PIX_W-1:0] wr_data;
        logic [IDX_W-1:0] rd_addr;
    } t_mem_req;

    typedef struct packed {
        logic [SUM_W-1:0] rem;
        logic [SUM_W-1:0] sum;
        logic [QUO_W-1:0] quo;
        logic             zero_sum;
        logic             sat;
        t_meta            meta;
    } t_div;

endpackage

FILE: rtl/core/npf_pix_mem.sv
// ============================================================================
// npf_pix_mem
// Pixel store: one write port, one read port with registered read data.
// ============================================================================
module npf_pix_mem #(
    parameter int DEPTH = 64
) (
    input  logic                        i_clk,
    input  npf_pkg::t_mem_req           i_req,
    input  logic                        i_rd_en,
    output logic [npf_pkg::PIX_W-1:0]   o_rd_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [npf_pkg::PIX_W-1:0] r_mem [DEPTH];
    logic [npf_pkg::PIX_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr[AW-1:0]] <= i_req.wr_data;
        end
    end

    // Hold read data while the pipeline stalls.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr[AW-1:0]];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/core/npf_div_stage.sv
// ============================================================================
// npf_div_stage
// One registered stage of the restoring divider, DIV_STEPS quotient bits.
// ============================================================================
module npf_div_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  logic           i_valid,
    input  npf_pkg::t_div  i_stage,
    output logic           o_valid,
    output npf_pkg::t_div  o_stage
);

    logic          r_valid;
    npf_pkg::t_div r_stage;
    npf_pkg::t_div n_stage;

    always_comb begin
        logic [npf_pkg::SUM_W:0] rem2;
        n_stage = i_stage;
        for (int k = 0; k < npf_pkg::DIV_STEPS; k++) begin
            rem2 = {n_stage.rem, 1'b0};
            if (rem2 >= {1'b0, n_stage.sum}) begin
                rem2 = rem2 - {1'b0, n_stage.sum};
                n_stage.quo = {n_stage.quo[npf_pkg::QUO_W-2:0], 1'b1};
            end else begin
                n_stage.quo = {n_stage.quo[npf_pkg::QUO_W-2:0], 1'b0};
            end
            n_stage.rem = rem2[npf_pkg::SUM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

FILE: rtl/core/npf_seq.sv
// ============================================================================
// npf_seq
// Pair sequencer: stores the pixel, then issues one pair per cycle while i_adv is high.
// ============================================================================
module npf_seq #(
    parameter int MAX_PIXELS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  npf_pkg::t_in                  i_in_word,
    input  logic                          i_cfg_we,
    input  logic [npf_pkg::NUM_W-1:0]     i_cfg_wdata,
    input  logic                          i_adv,
    output npf_pkg::t_mem_req             o_mem,
    output logic                          o_iss_valid,
    output npf_pkg::t_iss                 o_iss
);

    localparam logic [npf_pkg::NUM_W-1:0] NUM_MAX = npf_pkg::NUM_W'(MAX_PIXELS);

    logic [npf_pkg::NUM_W-1:0]  r_num, n_num;
    logic [npf_pkg::IDX_W-1:0]  r_pos, n_pos;
    logic                       r_busy, n_busy;
    logic [npf_pkg::IDX_W-1:0]  r_i, n_i;
    logic [npf_pkg::IDX_W-1:0]  r_j, n_j;
    logic [npf_pkg::NUM_W-1:0]  r_n, n_n;
    logic [npf_pkg::FIDX_W-1:0] r_d, n_d;
    logic [npf_pkg::PIX_W-1:0]  r_b, n_b;

    logic                       w_acc;
    logic                       w_iss;
    logic [npf_pkg::NUM_W-1:0]  w_n_eff;
    logic [npf_pkg::IDX_W-1:0]  w_j;
    logic [npf_pkg::NUM_W-1:0]  w_j1;
    logic                       w_last;

    assign w_acc = i_in_valid && !r_busy;
    assign w_iss = r_busy && i_adv;

    always_comb begin
        if (r_num < npf_pkg::NUM_MIN) begin
            w_n_eff = npf_pkg::NUM_MIN;
        end else if (r_num > NUM_MAX) begin
            w_n_eff = NUM_MAX;
        end else begin
            w_n_eff = r_num;
        end
    end

    assign w_j    = (i_in_word.start_patch || ({1'b0, r_pos} >= w_n_eff)) ? '0 : r_pos;
    assign w_j1   = {1'b0, w_j} + 7'd1;
    assign w_last = ({1'b0, r_i} + 7'd1) == {1'b0, r_j};

    always_comb begin
        n_num  = i_cfg_we ? i_cfg_wdata : r_num;
        n_pos  = r_pos;
        n_busy = r_busy;
        n_i    = r_i;
        n_j    = r_j;
        n_n    = r_n;
        n_d    = r_d;
        n_b    = r_b;
        if (w_acc) begin
            n_pos  = (w_j1 >= w_n_eff) ? '0 : w_j1[npf_pkg::IDX_W-1:0];
            n_busy = (w_j != '0);
            n_i    = '0;
            n_j    = w_j;
            n_n    = w_n_eff;
            n_d    = {5'd0, w_j} - 11'd1;
            n_b    = i_in_word.pixel;
        end else if (w_iss) begin
            // Step the row-major index: d(i+1) = d(i) + n - i - 2.
            n_i    = r_i + 6'd1;
            n_d    = r_d + ({4'd0, r_n} - {5'd0, r_i} - 11'd2);
            n_busy = !w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num  <= npf_pkg::NUM_RESET;
            r_pos  <= '0;
            r_busy <= 1'b0;
        end else begin
            r_num  <= n_num;
            r_pos  <= n_pos;
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i <= n_i;
        r_j <= n_j;
        r_n <= n_n;
        r_d <= n_d;
        r_b <= n_b;
    end

    assign o_in_ready = !r_busy;

    assign o_mem.wr_en   = w_acc;
    assign o_mem.wr_addr = w_j;
    assign o_mem.wr_data = i_in_word.pixel;
    assign o_mem.rd_addr = r_i;

    assign o_iss_valid             = w_iss;
    assign o_iss.b                 = r_b;
    assign o_iss.meta.feature_index = r_d;
    assign o_iss.meta.first_index  = r_i;
    assign o_iss.meta.second_index = r_j;
    assign o_iss.meta.last         = w_last;
    assign o_iss.meta.patch_end    = w_last && (({1'b0, r_j} + 7'd1) == r_n);

endmodule

FILE: rtl/core/npd_pairwise_feature_top.sv
// ============================================================================
// npd_pairwise_feature_top
// Normalized pixel difference feature generator: pairs each new pixel with
// every earlier pixel of the patch and emits floor(256*a/(a+b)).
// ============================================================================
//
//   channel  | valid       | ready        | word
//   ---------+-------------+--------------+----------------------------
//   input    | i_in_valid  | o_in_ready   | i_in_word  (t_in)
//   output   | o_out_valid | i_out_ready  | o_out_word (t_out)
//   config   | i_cfg_we    | (none)       | i_cfg_wdata (num_pixels)
//
// At the sequencer pixel j is first stored, then its j pairs are issued one
// per cycle from the pixel store read port while the output is not stalled.
// From pair issue to the output register a pair passes the store read,
// four divider stages of two quotient bits each, and the output register.
// Reset (synchronous, active low) clears position to zero, num_pixels to 64
// and all valid flags; the pixel store needs no clearing.
// A stalled output word freezes the whole pipe, and issue with it; a new pixel
// is taken as soon as the previous pixel has issued its last pair.
// ============================================================================
module npd_pairwise_feature_top #(
    parameter int MAX_PIXELS = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  npf_pkg::t_in               i_in_word,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output npf_pkg::t_out              o_out_word,
    input  logic                       i_cfg_we,
    input  logic [npf_pkg::NUM_W-1:0]  i_cfg_wdata
);

    localparam int NUM_PAIRS = MAX_PIXELS * (MAX_PIXELS - 1) / 2;

    // Pipe advances whenever the output register is empty or being drained.
    logic                       w_adv;
    npf_pkg::t_mem_req          w_mem;
    logic                       w_iss_valid;
    npf_pkg::t_iss              w_iss;
    logic [npf_pkg::PIX_W-1:0]  w_rd_data;

    logic                       r_s1_valid;
    npf_pkg::t_iss              r_s1;

    npf_pkg::t_div              w_ds0;
    logic                       w_dv [npf_pkg::DIV_STAGES+1];
    npf_pkg::t_div              w_ds [npf_pkg::DIV_STAGES+1];

    logic                       r_out_valid;
    npf_pkg::t_out              r_out_word;
    npf_pkg::t_out              n_out_word;

    assign w_adv = !r_out_valid || i_out_ready;

    npf_seq #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_adv       (w_adv),
        .o_mem       (w_mem),
        .o_iss_valid (w_iss_valid),
        .o_iss       (w_iss)
    );

    npf_pix_mem #(
        .DEPTH (MAX_PIXELS)
    ) u_mem (
        .i_clk     (i_clk),
        .i_req     (w_mem),
        .i_rd_en   (w_adv),
        .o_rd_data (w_rd_data)
    );

    // Carry the pair alongside the store read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= w_iss_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1 <= w_iss;
        end
    end

    // Divider setup: dividend is a * 256, so the remainder starts at a.
    always_comb begin
        w_ds0.sum      = {1'b0, w_rd_data} + {1'b0, r_s1.b};
        w_ds0.rem      = {1'b0, w_rd_data};
        w_ds0.quo      = '0;
        w_ds0.zero_sum = (w_rd_data == '0) && (r_s1.b == '0);
        w_ds0.sat      = (r_s1.b == '0);
        w_ds0.meta     = r_s1.meta;
    end

    assign w_dv[0] = r_s1_valid;
    assign w_ds[0] = w_ds0;

    for (genvar g = 0; g < npf_pkg::DIV_STAGES; g++) begin : g_div
        npf_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_valid (w_dv[g]),
            .i_stage (w_ds[g]),
            .o_valid (w_dv[g+1]),
            .o_stage (w_ds[g+1])
        );
    end

    // Both zero gives the midpoint; b zero with a nonzero saturates.
    always_comb begin
        if (w_ds[npf_pkg::DIV_STAGES].zero_sum) begin
            n_out_word.feature = npf_pkg::FEAT_BOTH_ZERO;
        end else if (w_ds[npf_pkg::DIV_STAGES].sat) begin
            n_out_word.feature = npf_pkg::FEAT_SAT;
        end else begin
            n_out_word.feature = w_ds[npf_pkg::DIV_STAGES].quo;
        end
        n_out_word.feature_index = w_ds[npf_pkg::DIV_STAGES].meta.feature_index;
        n_out_word.first_index   = w_ds[npf_pkg::DIV_STAGES].meta.first_index;
        n_out_word.second_index  = w_ds[npf_pkg::DIV_STAGES].meta.second_index;
        n_out_word.last          = w_ds[npf_pkg::DIV_STAGES].meta.last;
        n_out_word.patch_end     = w_ds[npf_pkg::DIV_STAGES].meta.patch_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_dv[npf_pkg::DIV_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.first_index < o_out_word.second_index))
        else $error("first index not below second index");

    a_last_adjacent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.last) |->
            (({1'b0, o_out_word.first_index} + 7'd1) == {1'b0, o_out_word.second_index}))
        else $error("last word is not the adjacent pair");

    a_patch_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.patch_end) |-> o_out_word.last)
        else $error("patch end without last");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ({21'd0, o_out_word.feature_index} < 32'(NUM_PAIRS)))
        else $error("feature index out of range");

    a_no_accept_while_issuing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_iss_valid |-> !(i_in_valid && o_in_ready))
        else $error("pixel accepted while pairs still issuing");

endmodule

FILE: tb/npd_pairwise_feature_top_test.sv
// ============================================================================
// npd_pairwise_feature_top_test
// Self-checking bench for the NPD pair feature generator. Pixels stream in
// over valid/ready, and a local model of the pixel store and the patch
// position predicts every pair word that must come out, in order. A short
// table of hand-picked pixels comes first. Random patches follow, under
// changing patch sizes and under four sender/receiver idling patterns.
// ============================================================================
module npd_pairwise_feature_top_test;
    import npf_pkg::*;

    localparam int MAX_PIX        = 64;
    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 8;
    localparam int SETTLE_CYCLES  = 16;      // issue + six-stage pipe, with margin
    localparam int RAND_PER_PHASE = 71;
    localparam int HEAVY_IDLE     = 87;      // percent
    localparam int LIGHT_IDLE     = 29;      // percent
    localparam int CYCLE_LIMIT    = 1000000;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    // One row of the directed table: optional size write, then one pixel word.
    // A hand-typed result is given only for pixels that make the single pair (0,1).
    typedef struct {
        bit               cfg;
        logic [NUM_W-1:0] cfg_val;
        t_in              word;
        bit               hand;
        t_out             hand_out;
    } stim_row_t;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_in_valid  = 1'b0;
    logic             o_in_ready;
    t_in              i_in_word   = '0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    t_out             o_out_word;
    logic             i_cfg_we    = 1'b0;
    logic [NUM_W-1:0] i_cfg_wdata = '0;

    // Model state: pixel store, next position, and the size register.
    logic [PIX_W-1:0] pix_mem [MAX_PIX];
    int               pix_pos    = 0;
    logic [NUM_W-1:0] num_pixels = NUM_RESET;

    t_out       pair_queue [$];
    stim_row_t  stim_rows  [$];
    idle_mode_t idle_mode  = IDLE_NONE;
    int         send_quiet = 0;
    int         recv_quiet = 0;
    int         errors     = 0;
    int         pixels_sent    = 0;
    int         pairs_checked  = 0;
    int         size_writes    = 0;
    int         cycles         = 0;
    t_out       want;

    npd_pairwise_feature_top #(
        .MAX_PIXELS (MAX_PIX)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Bound the run; a hang anywhere ends here.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d pairs still pending",
                     $time, cycles, pair_queue.size());
            $display("npd_pairwise_feature_top test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Model
    // ------------------------------------------------------------------------

    // Clamp the size register into 2..MAX_PIX, the size the block really uses.
    function automatic int patch_size(logic [NUM_W-1:0] reg_val);
        if (reg_val < NUM_MIN)
            return NUM_MIN;
        if (reg_val > MAX_PIX)
            return MAX_PIX;
        return reg_val;
    endfunction

    // floor(256*a/(a+b)), saturated at 255; both zero gives the midpoint.
    function automatic logic [PIX_W-1:0] npd_of(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
        int sum;
        int q;
        sum = a + b;
        if (sum == 0)
            return FEAT_BOTH_ZERO;
        q = (256 * a) / sum;
        if (q > 255)
            return FEAT_SAT;
        return PIX_W'(q);
    endfunction

    // Store one accepted pixel and queue one pair word per earlier pixel.
    function automatic void compute_pairs(t_in w);
        int   n;
        int   j;
        int   i;
        t_out r;
        n = patch_size(num_pixels);
        // A start flag, or a size shrunk below the position, opens a new patch.
        if (w.start_patch || pix_pos >= n)
            pix_pos = 0;
        j = pix_pos;
        pix_mem[j] = w.pixel;
        for (i = 0; i < j; i++) begin
            r.feature       = npd_of(pix_mem[i], w.pixel);
            // Row-major upper-triangle numbering, i outer and j inner.
            r.feature_index = FIDX_W'(i * n - (i * (i + 1)) / 2 + (j - i - 1));
            r.first_index   = IDX_W'(i);
            r.second_index  = IDX_W'(j);
            r.last          = (i + 1 == j);
            r.patch_end     = (i + 1 == j) && (j + 1 == n);
            pair_queue.push_back(r);
        end
        pix_pos = (j + 1 >= n) ? 0 : j + 1;
    endfunction

    // ------------------------------------------------------------------------
    // Receiver: drive ready at the falling edge, check words at the rising edge
    // ------------------------------------------------------------------------

    always @(negedge i_clk) begin
        if (recv_quiet > 0) begin
            // Hold ready high through a calm stretch.
            recv_quiet  = recv_quiet - 1;
            i_out_ready = 1'b1;
        end else if ($urandom_range(0, 63) == 0) begin
            recv_quiet  = $urandom_range(10, 40);
            i_out_ready = 1'b1;
        end else begin
            case (idle_mode)
                IDLE_RECEIVER: i_out_ready = ($urandom_range(0, 99) >= HEAVY_IDLE);
                IDLE_BOTH:     i_out_ready = ($urandom_range(0, 99) >= LIGHT_IDLE);
                default:       i_out_ready = 1'b1;
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pair_queue.size() == 0) begin
                errors = errors + 1;
                $display("%0t: unexpected word, expected none, actual %p", $time, o_out_word);
            end else begin
                want = pair_queue.pop_front();
                pairs_checked = pairs_checked + 1;
                if (o_out_word.feature       !== want.feature       ||
                    o_out_word.feature_index !== want.feature_index ||
                    o_out_word.first_index   !== want.first_index   ||
                    o_out_word.second_index  !== want.second_index  ||
                    o_out_word.last          !== want.last          ||
                    o_out_word.patch_end     !== want.patch_end) begin
                    errors = errors + 1;
                    $display("%0t: mismatch, expected %p, actual %p", $time, want, o_out_word);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------

    // Enter and leave at a falling edge. Valid stays high from one word to the
    // next when no gap is taken, so it is never dropped and raised in one step.
    task automatic send_pixel(input t_in w, input bit hand, input t_out hand_out);
        bit idle;
        forever begin
            case (idle_mode)
                IDLE_SENDER: idle = ($urandom_range(0, 99) < HEAVY_IDLE);
                IDLE_BOTH:   idle = ($urandom_range(0, 99) < LIGHT_IDLE);
                default:     idle = 1'b0;
            endcase
            if (!idle || send_quiet > 0)
                break;
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_word  = w;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        compute_pairs(w);
        if (hand) begin
            // Replace the computed pair with the hand-typed one.
            void'(pair_queue.pop_back());
            pair_queue.push_back(hand_out);
        end
        pixels_sent = pixels_sent + 1;
        if (send_quiet > 0)
            send_quiet = send_quiet - 1;
        else if ($urandom_range(0, 49) == 0)
            send_quiet = $urandom_range(8, 30);
        @(negedge i_clk);
    endtask

    // Drop valid, wait for every pending pair, then let the pipe go quiet.
    // A pixel that makes no pair may still be in flight, hence the settle time.
    task automatic drain_and_settle();
        i_in_valid = 1'b0;
        while (pair_queue.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_num_pixels(input logic [NUM_W-1:0] val);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = val;
        num_pixels  = val;
        size_writes = size_writes + 1;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    function automatic void add_row(bit cfg, logic [NUM_W-1:0] cfg_val,
                                    logic [PIX_W-1:0] pix, bit start,
                                    bit hand, logic [PIX_W-1:0] feat, bit pend);
        stim_row_t row;
        row.cfg                    = cfg;
        row.cfg_val                = cfg_val;
        row.word.pixel             = pix;
        row.word.start_patch       = start;
        row.hand                   = hand;
        row.hand_out.feature       = feat;
        row.hand_out.feature_index = '0;
        row.hand_out.first_index   = '0;
        row.hand_out.second_index  = IDX_W'(1);
        row.hand_out.last          = 1'b1;
        row.hand_out.patch_end     = pend;
        stim_rows.push_back(row);
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    initial begin
        int               r;
        int               ph;
        int               sent;
        int               pick;
        int               n_eff;
        int               patches;
        int               k;
        logic [NUM_W-1:0] size_val;
        t_in              w;

        // Directed table, starting from the reset size of 64.
        //       cfg  size    pixel   start hand feat    patch_end
        add_row(0,   7'd0,   8'h00,  1,    0,   8'd0,   0);   // first pixel: no pairs
        add_row(0,   7'd0,   8'h00,  0,    1,   8'd128, 0);   // both zero
        add_row(0,   7'd0,   8'hFF,  1,    0,   8'd0,   0);   // start in mid-patch
        add_row(0,   7'd0,   8'h00,  0,    1,   8'd255, 0);   // 256 saturates
        add_row(0,   7'd0,   8'h00,  1,    0,   8'd0,   0);
        add_row(0,   7'd0,   8'hFF,  0,    1,   8'd0,   0);   // a zero
        add_row(0,   7'd0,   8'h01,  1,    0,   8'd0,   0);
        add_row(0,   7'd0,   8'hFF,  0,    1,   8'd1,   0);
        add_row(0,   7'd0,   8'hAA,  1,    0,   8'd0,   0);
        add_row(0,   7'd0,   8'h55,  0,    0,   8'd0,   0);
        add_row(0,   7'd0,   8'hFF,  0,    0,   8'd0,   0);
        add_row(0,   7'd0,   8'h00,  0,    0,   8'd0,   0);
        add_row(0,   7'd0,   8'h80,  0,    0,   8'd0,   0);
        add_row(1,   7'd2,   8'd100, 0,    0,   8'd0,   0);   // shrink below position
        add_row(0,   7'd0,   8'd100, 0,    1,   8'd128, 1);
        add_row(0,   7'd0,   8'd50,  0,    0,   8'd0,   0);   // wrap after last pixel
        add_row(0,   7'd0,   8'd150, 0,    1,   8'd64,  1);
        add_row(1,   7'd0,   8'd9,   0,    0,   8'd0,   0);   // size 0 acts as 2
        add_row(0,   7'd0,   8'd9,   0,    1,   8'd128, 1);
        add_row(1,   7'd1,   8'hFF,  0,    0,   8'd0,   0);   // size 1 acts as 2
        add_row(0,   7'd0,   8'hFF,  0,    1,   8'd128, 1);
        add_row(1,   7'd127, 8'h7F,  1,    0,   8'd0,   0);   // above max acts as 64
        add_row(0,   7'd0,   8'h80,  0,    0,   8'd0,   0);
        add_row(0,   7'd0,   8'h01,  0,    0,   8'd0,   0);
        add_row(1,   7'd3,   8'hFE,  0,    0,   8'd0,   0);   // shrink again
        add_row(0,   7'd0,   8'h02,  0,    0,   8'd0,   0);
        add_row(0,   7'd0,   8'hFD,  0,    0,   8'd0,   0);

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Walk the table.
        for (r = 0; r < stim_rows.size(); r++) begin
            if (stim_rows[r].cfg) begin
                drain_and_settle();
                write_num_pixels(stim_rows[r].cfg_val);
            end
            send_pixel(stim_rows[r].word, stim_rows[r].hand, stim_rows[r].hand_out);
        end

        // Random patches, one idling pattern per phase. Mostly whole patches
        // opened by a start flag; some cut short, some with a stray start.
        for (ph = 0; ph < 4; ph++) begin
            drain_and_settle();
            idle_mode = idle_mode_t'(ph);
            sent = 0;
            while (sent < RAND_PER_PHASE) begin
                pick = $urandom_range(0, 15);
                if (pick == 0)
                    size_val = $urandom_range(0, 1) ? 7'd64 : NUM_W'($urandom_range(65, 127));
                else if (pick == 1)
                    size_val = NUM_W'($urandom_range(33, 63));
                else if (pick == 2)
                    size_val = NUM_W'($urandom_range(0, 1));
                else
                    size_val = NUM_W'($urandom_range(2, 10));
                drain_and_settle();
                write_num_pixels(size_val);
                n_eff   = patch_size(size_val);
                patches = $urandom_range(1, 4);
                while (patches > 0 && sent < RAND_PER_PHASE) begin
                    for (k = 0; k < n_eff && sent < RAND_PER_PHASE; k++) begin
                        if (k > 0 && $urandom_range(0, 11) == 0)
                            break;
                        if (k == 0)
                            w.start_patch = ($urandom_range(0, 3) != 0);
                        else
                            w.start_patch = ($urandom_range(0, 29) == 0);
                        case ($urandom_range(0, 9))
                            0:       w.pixel = 8'h00;
                            1:       w.pixel = 8'hFF;
                            default: w.pixel = PIX_W'($urandom);
                        endcase
                        send_pixel(w, 1'b0, '0);
                        sent = sent + 1;
                    end
                    patches = patches - 1;
                end
            end
        end

        // Let the last pairs come out, then watch for strays.
        drain_and_settle();

        $display("Sent %0d pixels under %0d patch-size writes and four idling patterns;",
                 pixels_sent, size_writes);
        $display("checked %0d pair features, %0d left unmatched.",
                 pairs_checked, pair_queue.size());
        if (errors == 0 && pair_queue.size() == 0) begin
            $display("npd_pairwise_feature_top test passed");
        end else begin
            $display("npd_pairwise_feature_top test failed");
        end
        $finish;
    end

endmodule
